// ===== rtl/core/lgrs_pkg.sv =====
// lgrs_pkg: shared types and constants of the light-gun report sequencer
// no dependencies; imported by the channel interface users and all rtl/core modules
package lgrs_pkg;

    // input function codes as seen on the item channel
    localparam logic [2:0] FUNC_READ    = 3'd0;
    localparam logic [2:0] FUNC_PRESS   = 3'd1;
    localparam logic [2:0] FUNC_RELEASE = 3'd2;
    localparam logic [2:0] FUNC_AIM_X   = 3'd3;
    localparam logic [2:0] FUNC_AIM_Y   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ID_LOW        = 2'd2;
    localparam logic [1:0] CFG_ID_HIGH       = 2'd3;

    // report steps
    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_ID_LO = 4'd1;
    localparam logic [3:0] STEP_ID_HI = 4'd2;
    localparam logic [3:0] STEP_BT_LO = 4'd3;
    localparam logic [3:0] STEP_BT_HI = 4'd4;
    localparam logic [3:0] STEP_X_LO  = 4'd5;
    localparam logic [3:0] STEP_X_HI  = 4'd6;
    localparam logic [3:0] STEP_Y_LO  = 4'd7;
    localparam logic [3:0] STEP_Y_HI  = 4'd8;

    localparam logic [7:0]  IDLE_BYTE = 8'hFF;

    // aim scaling
    localparam int SPAN_W     = 9;
    localparam int DIVIDEND_W = 16 + SPAN_W;
    localparam logic [SPAN_W-1:0] X_SPAN = 9'd384;
    localparam logic [SPAN_W-1:0] Y_SPAN = 9'd223;
    localparam logic [15:0] X_OFFSET = 16'd77;
    localparam logic [15:0] Y_OFFSET = 16'd25;

    // reset values
    localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd384;
    localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd240;
    localparam logic [7:0]  RST_ID_LOW        = 8'd99;
    localparam logic [7:0]  RST_ID_HIGH       = 8'd90;
    localparam logic [15:0] RST_BUTTONS       = 16'hFFFF;
    localparam logic [15:0] RST_AIM_X         = 16'h004D;
    localparam logic [15:0] RST_AIM_Y         = 16'h0019;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_PRESS   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_AIM_X   = 3'd3,
        OP_AIM_Y   = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       more_pending;
    } result_t;

    typedef struct packed {
        logic [1:0]  addr;
        logic [15:0] data;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [7:0]  id_low;
        logic [7:0]  id_high;
    } cfg_set_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [15:0]           divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/lgrs_chan_if.sv =====
// lgrs_chan_if: valid/ready channel carrying one payload beat
// payload type given per instance; used with lgrs_pkg structs
interface lgrs_chan_if #(parameter type payload_t = logic [7:0]) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lightgun_report_sequencer.sv =====
// lightgun_report_sequencer: a read beat is queued, then the back end registers its result byte;
// press and release are carried out by the back end from idle, unused codes are dropped at the front;
// aim beats run dispatch, product setup, 25 divider steps, write-back; one quotient bit a cycle.
// a two-entry command queue lets up to two commands wait while the back end works.
// rst_n is asynchronous, active low; it restores config and report state to defaults.
module lightgun_report_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    lgrs_chan_if.sink   item_in,
    lgrs_chan_if.source result_out,
    lgrs_chan_if.sink   cfg
);
    import lgrs_pkg::*;

    cfg_set_t cfg_set_reg, cfg_set_next;
    logic     cmd_valid, cmd_ready;
    cmd_t     cmd;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_set_next = cfg_set_reg;
        if (cfg.valid)
        begin
            unique case (cfg.payload.addr)
                CFG_SCREEN_WIDTH:  cfg_set_next.screen_width  = cfg.payload.data;
                CFG_SCREEN_HEIGHT: cfg_set_next.screen_height = cfg.payload.data;
                CFG_ID_LOW:        cfg_set_next.id_low        = cfg.payload.data[7:0];
                CFG_ID_HIGH:       cfg_set_next.id_high       = cfg.payload.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_set_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_set_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_set_reg.id_low        <= RST_ID_LOW;
            cfg_set_reg.id_high       <= RST_ID_HIGH;
        end
        else
        begin
            cfg_set_reg <= cfg_set_next;
        end
    end

    // front end: accept and queue
    lgrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // back end: execute and return results
    lgrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready),
        .cfg        (cfg_set_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .result_out (result_out)
    );

    // aim scaling divider
    lgrs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== rtl/core/lgrs_divider.sv =====
// lgrs_divider: restoring divider, one quotient bit per cycle, 16-bit saturated result
// depends on lgrs_pkg for div_req_t, div_rsp_t and DIVIDEND_W
module lgrs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  lgrs_pkg::div_req_t req,
    output lgrs_pkg::div_rsp_t rsp
);
    import lgrs_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [15:0]           rem_reg, rem_next;
    logic [15:0]           dvs_reg, dvs_next;

    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    // one restoring step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = rem_sh >= {1'b0, dvs_reg};
    end

    // step sequencing; a zero divisor gives all ones, which saturates
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[15:0] : rem_sh[15:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // saturate to 16 bits
    always_comb
    begin
        rsp.done     = done_reg;
        rsp.quotient = (|quo_reg[DIVIDEND_W-1:16]) ? 16'hFFFF : quo_reg[15:0];
    end

endmodule

// ===== rtl/core/lgrs_front.sv =====
// lgrs_front: accepts item beats, decodes the function code and queues commands
// depends on lgrs_pkg and lgrs_chan_if
module lgrs_front (
    input  logic           clk,
    input  logic           rst_n,
    lgrs_chan_if.sink      item_in,
    output logic           cmd_valid,
    output lgrs_pkg::cmd_t cmd,
    input  logic           cmd_ready
);
    import lgrs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic accept, push, pop, is_cmd;
    op_t  op;

    // decode; unused codes are taken and dropped
    always_comb
    begin
        is_cmd = 1'b1;
        op     = OP_READ;
        unique case (item_in.payload.func)
            FUNC_READ:    op = OP_READ;
            FUNC_PRESS:   op = OP_PRESS;
            FUNC_RELEASE: op = OP_RELEASE;
            FUNC_AIM_X:   op = OP_AIM_X;
            FUNC_AIM_Y:   op = OP_AIM_Y;
            default:      is_cmd = 1'b0;
        endcase
    end

    assign item_in.ready = (count_reg != FULL_CNT);
    assign accept        = item_in.valid && item_in.ready;
    assign push          = accept && is_cmd;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = queue_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op, value: item_in.payload.value};
        end
    end

endmodule

// ===== rtl/core/lgrs_back.sv =====
// lgrs_back: carries out queued commands, holds report state and the result register
// depends on lgrs_pkg, lgrs_chan_if and an lgrs_divider on div_req/div_rsp
module lgrs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  lgrs_pkg::cmd_t     cmd,
    output logic               cmd_ready,
    input  lgrs_pkg::cfg_set_t cfg,
    output lgrs_pkg::div_req_t div_req,
    input  lgrs_pkg::div_rsp_t div_rsp,
    lgrs_chan_if.source        result_out
);
    import lgrs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [15:0] buttons_reg, buttons_next;
    logic [15:0] aim_x_reg, aim_x_next;
    logic [15:0] aim_y_reg, aim_y_next;
    logic        axis_y_reg, axis_y_next;
    logic [15:0] value_reg, value_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        out_free, pop;
    logic [7:0]  byte_sel;
    logic [15:0] aim_sum;

    assign out_free  = !out_valid_reg || result_out.ready;
    assign cmd_ready = (state_reg == S_IDLE) && (cmd.op != OP_READ || out_free);
    assign pop       = cmd_valid && cmd_ready;

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_reg;

    // report byte for the current step; an out-of-range step reads as idle
    always_comb
    begin
        unique case (step_reg)
            STEP_ID_LO: byte_sel = cfg.id_low;
            STEP_ID_HI: byte_sel = cfg.id_high;
            STEP_BT_LO: byte_sel = buttons_reg[7:0];
            STEP_BT_HI: byte_sel = buttons_reg[15:8];
            STEP_X_LO:  byte_sel = aim_x_reg[7:0];
            STEP_X_HI:  byte_sel = aim_x_reg[15:8];
            STEP_Y_LO:  byte_sel = aim_y_reg[7:0];
            STEP_Y_HI:  byte_sel = aim_y_reg[15:8];
            default:    byte_sel = IDLE_BYTE;
        endcase
    end

    // scaled coordinate plus offset, wrapping at 16 bits
    assign aim_sum = div_rsp.quotient + (axis_y_reg ? Y_OFFSET : X_OFFSET);

    // divider request: product registered inside the divider
    always_comb
    begin
        div_req.start    = (state_reg == S_MUL);
        div_req.dividend = DIVIDEND_W'(value_reg)
                         * DIVIDEND_W'(axis_y_reg ? Y_SPAN : X_SPAN);
        div_req.divisor  = axis_y_reg ? cfg.screen_height : cfg.screen_width;
    end

    // command execution
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        ready_flag_next = ready_flag_reg;
        buttons_next    = buttons_reg;
        aim_x_next      = aim_x_reg;
        aim_y_next      = aim_y_reg;
        axis_y_next     = axis_y_reg;
        value_next      = value_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    unique case (cmd.op)
                        OP_READ:
                        begin
                            out_valid_next = 1'b1;
                            if (step_reg == STEP_Y_HI)
                            begin
                                ready_flag_next = 1'b0;
                                step_next       = STEP_IDLE;
                            end
                            else if (step_reg > STEP_Y_HI)
                            begin
                                ready_flag_next = 1'b1;
                                step_next       = STEP_ID_LO;
                            end
                            else
                            begin
                                ready_flag_next = 1'b1;
                                step_next       = step_reg + 1'b1;
                            end
                            out_next.read_byte    = byte_sel;
                            out_next.more_pending = ready_flag_next;
                        end
                        OP_PRESS:   buttons_next = buttons_reg & ~cmd.value;
                        OP_RELEASE: buttons_next = buttons_reg | cmd.value;
                        OP_AIM_X, OP_AIM_Y:
                        begin
                            axis_y_next = (cmd.op == OP_AIM_Y);
                            value_next  = cmd.value;
                            state_next  = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (axis_y_reg)
                    begin
                        aim_y_next = aim_sum;
                    end
                    else
                    begin
                        aim_x_next = aim_sum;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= STEP_IDLE;
            ready_flag_reg <= 1'b1;
            buttons_reg    <= RST_BUTTONS;
            aim_x_reg      <= RST_AIM_X;
            aim_y_reg      <= RST_AIM_Y;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            ready_flag_reg <= ready_flag_next;
            buttons_reg    <= buttons_next;
            aim_x_reg      <= aim_x_next;
            aim_y_reg      <= aim_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_y_reg <= axis_y_next;
        value_reg  <= value_next;
        out_reg    <= out_next;
    end

endmodule

// ===== rtl/core/lgrs_checker.sv =====
// lgrs_checker: port-level assertions for lightgun_report_sequencer, bound below
// depends on lgrs_pkg for function codes and the idle byte
module lgrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_func,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_read_byte,
    input logic        out_more_pending,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    import lgrs_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       last_final_reg;
    logic       read_beat, out_beat;

    assign read_beat = in_valid && in_ready && (in_func == FUNC_READ);
    assign out_beat  = out_valid && out_ready;

    // reads accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        priority if (read_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_beat && !read_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_final_reg <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_beat)
            begin
                last_final_reg <= !out_more_pending;
            end
        end
    end

    // no result without an outstanding read
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result beat with no outstanding read");

    // report restarts with the idle byte after reset or after the last byte
    a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_final_reg) |-> (out_read_byte == IDLE_BYTE && out_more_pending))
        else $error("report did not restart with the idle byte");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_read_byte) && $stable(out_more_pending)))
        else $error("stalled result beat changed");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration beat stalled");

endmodule

bind lightgun_report_sequencer lgrs_checker u_lgrs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item_in.valid),
    .in_ready         (item_in.ready),
    .in_func          (item_in.payload.func),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .out_read_byte    (result_out.payload.read_byte),
    .out_more_pending (result_out.payload.more_pending),
    .cfg_valid        (cfg.valid),
    .cfg_ready        (cfg.ready)
);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for lightgun_report_sequencer, directed and random beats
// depends on lgrs_pkg and lgrs_chan_if; tracks the report state and checks each read byte
module testbench;
    import lgrs_pkg::*;

    // func codes the block treats as no-ops
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 175;
    localparam int NUM_PHASES    = 5;
    localparam int LIMIT_TIME    = 800000;

    // tracks the report state and holds the read bytes still owed by the block
    class gun_report_tracker;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  id_low;
        logic [7:0]  id_high;
        logic [3:0]  step;
        logic [15:0] buttons;
        logic [15:0] aim_x;
        logic [15:0] aim_y;
        logic        ready_flag;
        result_t     pending_bytes[$];
        int          mismatch_count;
        int          bytes_checked;

        function new();
            width          = RST_SCREEN_WIDTH;
            height         = RST_SCREEN_HEIGHT;
            id_low         = RST_ID_LOW;
            id_high        = RST_ID_HIGH;
            step           = STEP_IDLE;
            buttons        = RST_BUTTONS;
            aim_x          = RST_AIM_X;
            aim_y          = RST_AIM_Y;
            ready_flag     = 1'b1;
            mismatch_count = 0;
            bytes_checked  = 0;
        endfunction

        task flag_mismatch(input string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        function void apply_config(input cfg_t w);
            case (w.addr)
                CFG_SCREEN_WIDTH:  width   = w.data;
                CFG_SCREEN_HEIGHT: height  = w.data;
                CFG_ID_LOW:        id_low  = w.data[7:0];
                CFG_ID_HIGH:       id_high = w.data[7:0];
                default: ;
            endcase
        endfunction

        // exact quotient, saturated to 16 bits, then offset with 16-bit wrap
        function logic [15:0] scale(input logic [15:0] v, input logic [SPAN_W-1:0] span,
                                    input logic [15:0] div, input logic [15:0] offset);
            logic [31:0] q;
            if (div == 16'd0)
                q = 32'hFFFF;
            else
            begin
                q = (32'(v) * 32'(span)) / 32'(div);
                if (q > 32'hFFFF)
                    q = 32'hFFFF;
            end
            return q[15:0] + offset;
        endfunction

        function void take_item(input item_t it);
            result_t r;
            case (it.func)
                FUNC_READ:
                begin
                    case (step)
                        STEP_ID_LO: r.read_byte = id_low;
                        STEP_ID_HI: r.read_byte = id_high;
                        STEP_BT_LO: r.read_byte = buttons[7:0];
                        STEP_BT_HI: r.read_byte = buttons[15:8];
                        STEP_X_LO:  r.read_byte = aim_x[7:0];
                        STEP_X_HI:  r.read_byte = aim_x[15:8];
                        STEP_Y_LO:  r.read_byte = aim_y[7:0];
                        STEP_Y_HI:  r.read_byte = aim_y[15:8];
                        default:
                        begin
                            r.read_byte = IDLE_BYTE;
                            step        = STEP_IDLE;
                        end
                    endcase
                    // last byte closes the report and drops the ready flag
                    if (step == STEP_Y_HI)
                    begin
                        ready_flag = 1'b0;
                        step       = STEP_IDLE;
                    end
                    else
                    begin
                        ready_flag = 1'b1;
                        step       = step + 4'd1;
                    end
                    r.more_pending = ready_flag;
                    pending_bytes.push_back(r);
                end
                FUNC_PRESS:   buttons = buttons & ~it.value;
                FUNC_RELEASE: buttons = buttons | it.value;
                FUNC_AIM_X:   aim_x = scale(it.value, X_SPAN, width, X_OFFSET);
                FUNC_AIM_Y:   aim_y = scale(it.value, Y_SPAN, height, Y_OFFSET);
                default: ;
            endcase
        endfunction

        task take_byte(input result_t got);
            result_t want;
            if (pending_bytes.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected read byte %02h", got.read_byte));
                return;
            end
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (got.read_byte !== want.read_byte)
                flag_mismatch($sformatf("read_byte %02h, expected %02h",
                                        got.read_byte, want.read_byte));
            if (got.more_pending !== want.more_pending)
                flag_mismatch($sformatf("more_pending %0b, expected %0b",
                                        got.more_pending, want.more_pending));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic hold_off;
    int   sender_idle_pct;
    int   recv_stall_pct;
    int   items_sent;
    int   items_taken;

    gun_report_tracker tracker = new();

    lgrs_chan_if #(.payload_t(item_t))   item_if ();
    lgrs_chan_if #(.payload_t(result_t)) result_if ();
    lgrs_chan_if #(.payload_t(cfg_t))    cfg_if ();

    lightgun_report_sequencer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, forced low during a hold-off
    always @(posedge clk)
        result_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // beat monitor: results checked before the input beat of the same edge is noted
    always @(posedge clk)
    begin
        if (result_if.valid && result_if.ready)
            tracker.take_byte(result_if.payload);
        if (item_if.valid && item_if.ready)
        begin
            tracker.take_item(item_if.payload);
            items_taken++;
        end
        if (cfg_if.valid && cfg_if.ready)
            tracker.apply_config(cfg_if.payload);
    end

    function automatic item_t make_item(input logic [2:0] func, input logic [15:0] value);
        item_t it;
        it.func  = func;
        it.value = value;
        return it;
    endfunction

    // extremes often, random the rest
    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // updates mostly, with no-op codes and stray reads as noise
    function automatic item_t pick_update();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return make_item(FUNC_PRESS, pick_value());
        else if (r < 4)
            return make_item(FUNC_RELEASE, pick_value());
        else if (r < 6)
            return make_item(FUNC_AIM_X, pick_value());
        else if (r < 8)
            return make_item(FUNC_AIM_Y, pick_value());
        else if (r == 8)
            return make_item(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                             pick_value());
        return make_item(FUNC_READ, pick_value());
    endfunction

    // one input beat, with random idle cycles in front
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_config(input logic [1:0] addr, input logic [15:0] data);
        cfg_if.valid        <= 1'b1;
        cfg_if.payload.addr <= addr;
        cfg_if.payload.data <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // report burst: a few updates, then a full report, sometimes cut short or interleaved
    task automatic send_report_burst();
        int reads;
        repeat ($urandom_range(4))
            send_item(pick_update());
        reads = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 9;
        repeat (reads)
        begin
            if ($urandom_range(7) == 0)
                send_item(pick_update());
            send_item(make_item(FUNC_READ, 16'($urandom)));
        end
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
            send_report_burst();
    endtask

    task automatic hold_results(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles)
            @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // wait for all owed bytes, then let any aim work in the back end finish
    task automatic wait_drained();
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1:
            begin
                // smallest divisors: most quotients saturate
                send_config(CFG_SCREEN_WIDTH, 16'd1);
                send_config(CFG_SCREEN_HEIGHT, 16'd1);
                send_config(CFG_ID_LOW, 16'hFF00);
                send_config(CFG_ID_HIGH, 16'h0000);
            end
            2:
            begin
                send_config(CFG_SCREEN_WIDTH, 16'hFFFF);
                send_config(CFG_SCREEN_HEIGHT, 16'hFFFF);
                send_config(CFG_ID_LOW, 16'h00FF);
                send_config(CFG_ID_HIGH, 16'hFFFF);
            end
            3:
            begin
                // zero divisors
                send_config(CFG_SCREEN_WIDTH, 16'd0);
                send_config(CFG_SCREEN_HEIGHT, 16'd0);
                send_config(CFG_ID_LOW, 16'($urandom));
                send_config(CFG_ID_HIGH, 16'($urandom));
            end
            default:
            begin
                send_config(CFG_SCREEN_WIDTH, 16'($urandom_range(1, 1024)));
                send_config(CFG_SCREEN_HEIGHT, 16'($urandom_range(1, 1024)));
                send_config(CFG_ID_LOW, 16'($urandom));
                send_config(CFG_ID_HIGH, 16'($urandom));
            end
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    // directed: reset report, extreme updates, no-op codes, report again
    task automatic run_directed();
        repeat (9)
            send_item(make_item(FUNC_READ, 16'h0000));
        send_item(make_item(FUNC_PRESS, 16'hFFFF));
        send_item(make_item(FUNC_RELEASE, 16'h5A5A));
        send_item(make_item(FUNC_AIM_X, 16'hFFFF));
        send_item(make_item(FUNC_AIM_Y, 16'h0000));
        send_item(make_item(FUNC_SPARE_FIRST, 16'hFFFF));
        send_item(make_item(FUNC_SPARE_LAST, 16'h0000));
        repeat (9)
            send_item(make_item(FUNC_READ, 16'hFFFF));
    endtask

    // stimulus
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        hold_off        = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        items_taken     = 0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        result_if.ready = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                configure(phase);
            end
            case (phase)
                1:       begin sender_idle_pct <= 49; recv_stall_pct <= 0;  end
                2:       begin sender_idle_pct <= 0;  recv_stall_pct <= 49; end
                3:       begin sender_idle_pct <= 27; recv_stall_pct <= 27; end
                default: begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
            endcase
            if (phase == 0)
            begin
                run_directed();
                run_random(PHASE_ITEMS);
            end
            else if (phase == NUM_PHASES - 1)
            begin
                // long receiver hold-off while beats keep coming
                fork
                    hold_results(HOLD_CYCLES);
                    run_random(PHASE_ITEMS);
                join
            end
            else
                run_random(PHASE_ITEMS);
            item_if.valid <= 1'b0;
        end

        wait_drained();
        if (tracker.pending_bytes.size() != 0)
            tracker.flag_mismatch($sformatf("%0d read bytes never arrived",
                                            tracker.pending_bytes.size()));
        $display("tb: %0d input beats over %0d screen settings, %0d read bytes checked",
                 items_taken, NUM_PHASES, tracker.bytes_checked);
        $display("tb: zero, unit and full-range divisors, no-op codes, long output hold-off");
        if (tracker.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // overall time limit
    initial
    begin
        #LIMIT_TIME;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lgrs_pkg.sv
rtl/core/lgrs_chan_if.sv
rtl/core/lgrs_divider.sv
rtl/core/lgrs_front.sv
rtl/core/lgrs_back.sv
rtl/core/lightgun_report_sequencer.sv
rtl/core/lgrs_checker.sv
bench/testbench.sv
